// ----- design/hglw_pkg.sv -----
// Shared constants, payload structs and divider handshake types for the hex line walker.
package hglw_pkg;

  localparam int COORD_BITS   = 16;
  localparam int FRAC_BITS    = 16;
  localparam int MAX_POINTS   = 64;
  localparam int CAP_BITS     = 7;
  localparam int N_BITS       = $clog2(MAX_POINTS);
  localparam int DELTA_BITS   = COORD_BITS + 2;
  localparam int MAG_BITS     = COORD_BITS + 1;
  localparam int DIV_BITS     = MAG_BITS + FRAC_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
  localparam int FIX_BITS     = COORD_BITS + FRAC_BITS;
  localparam int NUM_CRD      = 3;

  localparam logic [FIX_BITS-1:0] HALF    = FIX_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [FIX_BITS-1:0] NUDGE_Q = FIX_BITS'(1);
  localparam logic [FIX_BITS-1:0] NUDGE_R = FIX_BITS'(1);
  localparam logic [FIX_BITS-1:0] NUDGE_S = FIX_BITS'(-2);

  typedef enum logic [1:0] {
    CRD_Q = 2'd0,
    CRD_R = 2'd1,
    CRD_S = 2'd2
  } crd_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_q;
    logic signed [COORD_BITS-1:0] start_r;
    logic signed [COORD_BITS-1:0] end_q;
    logic signed [COORD_BITS-1:0] end_r;
  } seg_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] cell_q;
    logic signed [COORD_BITS-1:0] cell_r;
    logic                         last_cell;
  } pt_item_t;

  typedef struct packed {
    logic                go;
    logic [MAG_BITS-1:0] mag;
    logic [N_BITS-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [FIX_BITS-1:0] quot;
    logic [N_BITS-1:0]   rmd;
  } div_rsp_t;

endpackage

// ----- design/hglw_div.sv -----
// Shift-subtract divider: (mag * 2^FRAC_BITS) / divisor, one quotient bit per cycle.
module hglw_div (
  input  logic              clk,
  input  logic              rst,
  input  hglw_pkg::div_req_t req,
  output hglw_pkg::div_rsp_t rsp
);

  logic                               busy;
  logic                               done;
  logic [hglw_pkg::DIV_CNT_BITS-1:0]  cnt;
  logic [hglw_pkg::DIV_BITS-1:0]      num;
  logic [hglw_pkg::N_BITS-1:0]        divisor;
  logic [hglw_pkg::N_BITS-1:0]        rmd;
  logic [hglw_pkg::FIX_BITS-1:0]      quot;
  logic [hglw_pkg::N_BITS:0]          trial;
  logic [hglw_pkg::N_BITS:0]          diff;
  logic                               ge;

  // Bring down the next numerator bit and try the subtract.
  assign trial = {rmd, num[hglw_pkg::DIV_BITS-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      num     <= {req.mag, {hglw_pkg::FRAC_BITS{1'b0}}};
      divisor <= req.divisor;
      rmd     <= '0;
      cnt     <= hglw_pkg::DIV_CNT_BITS'(hglw_pkg::DIV_BITS - 1);
    end else if (busy) begin
      num  <= num << 1;
      rmd  <= ge ? diff[hglw_pkg::N_BITS-1:0] : trial[hglw_pkg::N_BITS-1:0];
      quot <= {quot[hglw_pkg::FIX_BITS-2:0], ge};
      cnt  <= cnt - 1'b1;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rmd  = rmd;

endmodule

// ----- design/hglw_round.sv -----
// Cube rounding of one interpolated point: round half up, rebuild the worst coordinate.
module hglw_round (
  input  logic [hglw_pkg::NUM_CRD-1:0][hglw_pkg::FIX_BITS-1:0] fix,
  output logic [hglw_pkg::COORD_BITS-1:0]                       k_q,
  output logic [hglw_pkg::COORD_BITS-1:0]                       k_r
);

  logic [hglw_pkg::NUM_CRD-1:0][hglw_pkg::FIX_BITS-1:0]   biased;
  logic [hglw_pkg::NUM_CRD-1:0][hglw_pkg::COORD_BITS-1:0] k;
  logic [hglw_pkg::NUM_CRD-1:0][hglw_pkg::FRAC_BITS-1:0]  low;
  logic [hglw_pkg::NUM_CRD-1:0][hglw_pkg::FRAC_BITS-1:0]  err;

  // Only the low bits matter, so modular arithmetic is exact here.
  always_comb begin
    for (int c = 0; c < hglw_pkg::NUM_CRD; c++) begin
      biased[c] = fix[c] + hglw_pkg::HALF;
      k[c]      = biased[c][hglw_pkg::FIX_BITS-1:hglw_pkg::FRAC_BITS];
      low[c]    = biased[c][hglw_pkg::FRAC_BITS-1:0];
      err[c]    = low[c][hglw_pkg::FRAC_BITS-1] ?
                  low[c] - hglw_pkg::HALF[hglw_pkg::FRAC_BITS-1:0] :
                  hglw_pkg::HALF[hglw_pkg::FRAC_BITS-1:0] - low[c];
    end
  end

  always_comb begin
    k_q = k[hglw_pkg::CRD_Q];
    k_r = k[hglw_pkg::CRD_R];
    priority if (err[hglw_pkg::CRD_Q] > err[hglw_pkg::CRD_R] &&
                 err[hglw_pkg::CRD_Q] > err[hglw_pkg::CRD_S]) begin
      k_q = -k[hglw_pkg::CRD_R] - k[hglw_pkg::CRD_S];
    end else if (err[hglw_pkg::CRD_R] > err[hglw_pkg::CRD_S]) begin
      k_r = -k[hglw_pkg::CRD_Q] - k[hglw_pkg::CRD_S];
    end else begin
      k_q = k[hglw_pkg::CRD_Q];
    end
  end

endmodule

// ----- design/hex_grid_line_walker_unit.sv -----
// Hex line walker top level: segment intake, shared divider sequencing, point stepping.
// Sequence: an accepted segment runs one 33-step shared divider pass per cube coordinate,
//   then steps its points; a zero-length run skips the divider.
// Each point: step, then round into the output register (held while pt_stall blocks it);
//   a new segment is taken only once the last of its N+1 points is in the output register.
// Reset (synchronous, rst high): FSM idle, output empty, max_points back to 64.
module hex_grid_line_walker_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             seg_valid,
  output logic                             seg_stall,
  input  hglw_pkg::seg_item_t              seg,
  output logic                             pt_valid,
  input  logic                             pt_stall,
  output hglw_pkg::pt_item_t               pt,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hglw_pkg::CAP_BITS-1:0]    cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_DIV   = 5'b00100,
    S_STEP  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  localparam int NC = hglw_pkg::NUM_CRD;
  localparam int FB = hglw_pkg::FIX_BITS;
  localparam int NB = hglw_pkg::N_BITS;

  state_t                                     state;
  logic [hglw_pkg::CAP_BITS-1:0]              max_points;

  // Per-segment operands, one lane per cube coordinate.
  logic [NC-1:0][hglw_pkg::COORD_BITS-1:0]    origin;
  logic [NC-1:0]                              neg;
  logic [NC-1:0][hglw_pkg::MAG_BITS-1:0]      mag;
  logic [NB-1:0]                              n;
  logic [NB-1:0]                              idx;
  hglw_pkg::crd_t                             crd;
  logic                                       div_go;

  // Per-point increments from the divider and the running quotient/remainder.
  logic [NC-1:0][FB-1:0]                      quo;
  logic [NC-1:0][NB-1:0]                      rmd;
  logic [NC-1:0][FB-1:0]                      acc;
  logic [NC-1:0][NB-1:0]                      rem;
  logic [NC-1:0][FB-1:0]                      acc_next;
  logic [NC-1:0][NB-1:0]                      rem_next;
  logic [NC-1:0][FB-1:0]                      fix;
  logic [NC-1:0][FB-1:0]                      fix_next;
  logic [NC-1:0][FB-1:0]                      nudge;
  logic                                       last;

  hglw_pkg::div_req_t                         div_req;
  hglw_pkg::div_rsp_t                         div_rsp;

  logic signed [hglw_pkg::DELTA_BITS-1:0]     d_q;
  logic signed [hglw_pkg::DELTA_BITS-1:0]     d_r;
  logic signed [hglw_pkg::DELTA_BITS-1:0]     d_s;
  logic [hglw_pkg::DELTA_BITS-1:0]            dist_sum;
  logic [hglw_pkg::MAG_BITS-1:0]              hex_dist;
  logic [NB-1:0]                              cap_m1;
  logic [NB-1:0]                              n_next;
  logic                                       seg_take;
  logic                                       out_free;
  logic                                       out_load;
  logic [hglw_pkg::COORD_BITS-1:0]            k_q;
  logic [hglw_pkg::COORD_BITS-1:0]            k_r;

  // Config writes must land only while idle (the user's duty; the block does not enforce it); the port is always open.
  assign cfg_ready = 1'b1;

  // Take a new segment only from idle; a waiting point does not block intake.
  assign seg_stall = (state != S_IDLE);
  assign seg_take  = seg_valid && !seg_stall;

  // Coordinate deltas; ds follows from the cube constraint.
  assign d_q = hglw_pkg::DELTA_BITS'(seg.end_q) - hglw_pkg::DELTA_BITS'(seg.start_q);
  assign d_r = hglw_pkg::DELTA_BITS'(seg.end_r) - hglw_pkg::DELTA_BITS'(seg.start_r);
  assign d_s = -(d_q + d_r);

  // Hex distance, then clamp the run by the point capacity.
  assign dist_sum = hglw_pkg::DELTA_BITS'(mag[hglw_pkg::CRD_Q])
                  + hglw_pkg::DELTA_BITS'(mag[hglw_pkg::CRD_R])
                  + hglw_pkg::DELTA_BITS'(mag[hglw_pkg::CRD_S]);
  assign hex_dist = dist_sum[hglw_pkg::DELTA_BITS-1:1];

  always_comb begin
    priority if (max_points == '0) begin
      cap_m1 = '0;
    end else if (max_points > hglw_pkg::CAP_BITS'(hglw_pkg::MAX_POINTS)) begin
      cap_m1 = NB'(hglw_pkg::MAX_POINTS - 1);
    end else begin
      cap_m1 = NB'(max_points - 1'b1);
    end
  end

  assign n_next = (hex_dist < hglw_pkg::MAG_BITS'(cap_m1)) ? NB'(hex_dist) : cap_m1;

  // Shared divider: one coordinate at a time.
  always_comb begin
    div_req.go      = div_go;
    div_req.divisor = n;
    unique case (crd)
      hglw_pkg::CRD_Q: div_req.mag = mag[hglw_pkg::CRD_Q];
      hglw_pkg::CRD_R: div_req.mag = mag[hglw_pkg::CRD_R];
      hglw_pkg::CRD_S: div_req.mag = mag[hglw_pkg::CRD_S];
      default:         div_req.mag = mag[hglw_pkg::CRD_Q];
    endcase
  end

  hglw_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign nudge[hglw_pkg::CRD_Q] = hglw_pkg::NUDGE_Q;
  assign nudge[hglw_pkg::CRD_R] = hglw_pkg::NUDGE_R;
  assign nudge[hglw_pkg::CRD_S] = hglw_pkg::NUDGE_S;

  // Advance floor(|d|*i*2^F/N) by one step: add quotient, fold the remainder once.
  // Form the fixed-point point as origin + sign(d)*acc + nudge.
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      logic [NB:0] rsum;
      logic        wrap;
      rsum        = {1'b0, rem[c]} + {1'b0, rmd[c]};
      wrap        = rsum >= {1'b0, n};
      rem_next[c] = wrap ? NB'(rsum - {1'b0, n}) : rsum[NB-1:0];
      acc_next[c] = acc[c] + quo[c] + FB'(wrap);
      fix_next[c] = {origin[c], {hglw_pkg::FRAC_BITS{1'b0}}}
                  + (neg[c] ? -acc[c] : acc[c]) + nudge[c];
    end
  end

  hglw_round u_round (
    .fix (fix),
    .k_q (k_q),
    .k_r (k_r)
  );

  assign out_free = !pt_valid || !pt_stall;
  assign out_load = (state == S_EMIT) && out_free;

  // Control: sequencer, config register, divider kick, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      max_points <= hglw_pkg::CAP_BITS'(hglw_pkg::MAX_POINTS);
      div_go     <= 1'b0;
      pt_valid   <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        max_points <= cfg_data;
      end
      if (out_load) begin
        pt_valid <= 1'b1;
      end else if (!pt_stall) begin
        pt_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (seg_take) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (n_next == '0) begin
            state <= S_STEP;
          end else begin
            div_go <= 1'b1;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (crd == hglw_pkg::CRD_S) begin
              state <= S_STEP;
            end else begin
              div_go <= 1'b1;
            end
          end
        end
        S_STEP: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= last ? S_IDLE : S_STEP;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (seg_take) begin
      origin[hglw_pkg::CRD_Q] <= seg.start_q;
      origin[hglw_pkg::CRD_R] <= seg.start_r;
      origin[hglw_pkg::CRD_S] <= -seg.start_q - seg.start_r;
      neg[hglw_pkg::CRD_Q]    <= d_q[hglw_pkg::DELTA_BITS-1];
      neg[hglw_pkg::CRD_R]    <= d_r[hglw_pkg::DELTA_BITS-1];
      neg[hglw_pkg::CRD_S]    <= d_s[hglw_pkg::DELTA_BITS-1];
      mag[hglw_pkg::CRD_Q]    <= hglw_pkg::MAG_BITS'(d_q[hglw_pkg::DELTA_BITS-1] ? -d_q : d_q);
      mag[hglw_pkg::CRD_R]    <= hglw_pkg::MAG_BITS'(d_r[hglw_pkg::DELTA_BITS-1] ? -d_r : d_r);
      mag[hglw_pkg::CRD_S]    <= hglw_pkg::MAG_BITS'(d_s[hglw_pkg::DELTA_BITS-1] ? -d_s : d_s);
    end
    if (state == S_SETUP) begin
      n   <= n_next;
      idx <= '0;
      crd <= hglw_pkg::CRD_Q;
      acc <= '0;
      rem <= '0;
    end
    if (state == S_DIV && div_rsp.done) begin
      quo[crd] <= div_rsp.quot;
      rmd[crd] <= div_rsp.rmd;
      if (crd != hglw_pkg::CRD_S) begin
        crd <= hglw_pkg::crd_t'(crd + 1'b1);
      end
    end
    if (state == S_STEP) begin
      fix  <= fix_next;
      last <= (idx == n);
      acc  <= acc_next;
      rem  <= rem_next;
    end
    if (out_load) begin
      pt.cell_q    <= k_q;
      pt.cell_r    <= k_r;
      pt.last_cell <= last;
      idx          <= idx + 1'b1;
    end
  end

`ifndef SYNTHESIS
  // The point index never runs past the run length.
  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> (idx <= n))
    else $error("point index beyond run length");

  // Remainders stay reduced below N while stepping.
  a_rem_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP && n != '0) |->
      (rem[hglw_pkg::CRD_Q] < n && rem[hglw_pkg::CRD_R] < n && rem[hglw_pkg::CRD_S] < n))
    else $error("step remainder not reduced");

  // Divider results only show up while the sequencer waits for them.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider finished outside divide phase");

  // Loading the final point returns the block to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && last) |=> (state == S_IDLE && pt_valid && pt.last_cell))
    else $error("final point did not close the run");
`endif

endmodule

// ----- bench/hex_grid_line_walker_unit_tb.sv -----
// Self-checking testbench for the hex line walker: predicted cell runs against the block.
module hex_grid_line_walker_unit_tb;

  // One unit of the fixed-point line position.
  localparam longint FIX_ONE = longint'(1) << hglw_pkg::FRAC_BITS;
  // Random segments per idling phase; three phases make up the random part.
  localparam int PHASE_SEGMENTS = 57;
  // Cycles to let pass once the last cell is back, before touching max_points.
  localparam int SETTLE_CYCLES = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic seg_valid = 1'b0;
  logic seg_stall;
  hglw_pkg::seg_item_t seg = '0;
  logic pt_valid;
  logic pt_stall = 1'b0;
  hglw_pkg::pt_item_t pt;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [hglw_pkg::CAP_BITS-1:0] cfg_data = '0;

  // Bench copy of the capacity register, followed on every accepted write.
  logic [hglw_pkg::CAP_BITS-1:0] line_cap = hglw_pkg::CAP_BITS'(hglw_pkg::MAX_POINTS);
  // Cells the block still owes, oldest first.
  hglw_pkg::pt_item_t pending_cells[$];
  int error_count = 0;
  // Idle percentages of the segment sender and the cell receiver.
  int tx_idle = 0;
  int rx_idle = 0;
  // Forces the receiver to stall for a long stretch.
  logic rx_hold = 1'b0;

  hex_grid_line_walker_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .seg_valid (seg_valid),
    .seg_stall (seg_stall),
    .seg       (seg),
    .pt_valid  (pt_valid),
    .pt_stall  (pt_stall),
    .pt        (pt),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Fixed-point position of one cube coordinate at step i of n, truncated toward zero.
  function automatic longint line_fix(longint c0, longint c1, longint i, longint n,
                                      longint nudge);
    return c0 * FIX_ONE + ((c1 - c0) * i * FIX_ONE) / n + nudge;
  endfunction

  // Round half up: floor((f + 1/2) / 1), the arithmetic shift floors.
  function automatic longint round_half_up(longint f);
    return (f + FIX_ONE / 2) >>> hglw_pkg::FRAC_BITS;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Append one owed cell at the tail.
  function automatic void queue_cell(hglw_pkg::pt_item_t c);
    pending_cells.insert(pending_cells.size(), c);
  endfunction

  // Work out the whole run of cells for one segment and queue them.
  function automatic void predict_line(hglw_pkg::seg_item_t s);
    longint q0, r0, s0, q1, r1, s1, hex_dist, cap, n;
    longint fq, fr, fs, kq, kr, ks, errq, errr, errs;
    hglw_pkg::pt_item_t want_pt;
    q0 = longint'($signed(s.start_q));
    r0 = longint'($signed(s.start_r));
    q1 = longint'($signed(s.end_q));
    r1 = longint'($signed(s.end_r));
    s0 = -q0 - r0;
    s1 = -q1 - r1;
    hex_dist = (mag(q1 - q0) + mag(r1 - r0) + mag(s1 - s0)) / 2;
    // Clamp the capacity: zero acts as one, anything above the maximum saturates.
    cap = longint'(line_cap);
    if (cap < 1) cap = 1;
    if (cap > hglw_pkg::MAX_POINTS) cap = hglw_pkg::MAX_POINTS;
    n = (hex_dist < cap - 1) ? hex_dist : cap - 1;
    if (n == 0) begin
      // Zero-length run: the start cell alone, flagged last.
      want_pt.cell_q = q0[hglw_pkg::COORD_BITS-1:0];
      want_pt.cell_r = r0[hglw_pkg::COORD_BITS-1:0];
      want_pt.last_cell = 1'b1;
      queue_cell(want_pt);
      return;
    end
    for (longint i = 0; i <= n; i++) begin
      fq = line_fix(q0, q1, i, n, 1);
      fr = line_fix(r0, r1, i, n, 1);
      fs = line_fix(s0, s1, i, n, -2);
      kq = round_half_up(fq);
      kr = round_half_up(fr);
      ks = round_half_up(fs);
      errq = mag(kq * FIX_ONE - fq);
      errr = mag(kr * FIX_ONE - fr);
      errs = mag(ks * FIX_ONE - fs);
      // Rebuild the coordinate that rounded worst; q only wins when strictly largest.
      if (errq > errr && errq > errs) kq = -kr - ks;
      else if (errr > errs) kr = -kq - ks;
      want_pt.cell_q = kq[hglw_pkg::COORD_BITS-1:0];
      want_pt.cell_r = kr[hglw_pkg::COORD_BITS-1:0];
      want_pt.last_cell = (i == n);
      queue_cell(want_pt);
    end
  endfunction

  function automatic hglw_pkg::seg_item_t segment(int q0, int r0, int q1, int r1);
    hglw_pkg::seg_item_t s;
    s.start_q = hglw_pkg::COORD_BITS'(q0);
    s.start_r = hglw_pkg::COORD_BITS'(r0);
    s.end_q = hglw_pkg::COORD_BITS'(q1);
    s.end_r = hglw_pkg::COORD_BITS'(r1);
    return s;
  endfunction

  // Mostly short lines near a random start; the rest are full-range lines, points and
  // lines along one axis.
  function automatic hglw_pkg::seg_item_t random_segment();
    hglw_pkg::seg_item_t s;
    int kind, dq, dr, span;
    kind = $urandom_range(9);
    s.start_q = hglw_pkg::COORD_BITS'($urandom);
    s.start_r = hglw_pkg::COORD_BITS'($urandom);
    span = ($urandom_range(7) == 0) ? 400 : 40;
    dq = int'($urandom_range(2 * span)) - span;
    dr = int'($urandom_range(2 * span)) - span;
    if (kind < 6) begin
      s.end_q = s.start_q + hglw_pkg::COORD_BITS'(dq);
      s.end_r = s.start_r + hglw_pkg::COORD_BITS'(dr);
    end else if (kind < 8) begin
      s.end_q = hglw_pkg::COORD_BITS'($urandom);
      s.end_r = hglw_pkg::COORD_BITS'($urandom);
    end else if (kind == 8) begin
      s.end_q = s.start_q;
      s.end_r = s.start_r;
    end else begin
      // Along the q axis, the r axis or the s axis.
      case ($urandom_range(2))
        0: begin
          s.end_q = s.start_q + hglw_pkg::COORD_BITS'(dq);
          s.end_r = s.start_r;
        end
        1: begin
          s.end_q = s.start_q;
          s.end_r = s.start_r + hglw_pkg::COORD_BITS'(dr);
        end
        default: begin
          s.end_q = s.start_q + hglw_pkg::COORD_BITS'(dq);
          s.end_r = s.start_r - hglw_pkg::COORD_BITS'(dq);
        end
      endcase
    end
    return s;
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR @%0t: %s", $time, what);
    error_count++;
  endtask

  // Offer one segment, idling first at the sender's rate; hold valid high afterwards
  // so back-to-back items need no extra edge.
  task automatic send_segment(hglw_pkg::seg_item_t s);
    while ($urandom_range(99) < tx_idle) begin
      seg_valid <= 1'b0;
      @(posedge clk);
    end
    seg <= s;
    seg_valid <= 1'b1;
    @(posedge clk);
    while (seg_stall) @(posedge clk);
    predict_line(s);
  endtask

  // Drop valid and wait until every owed cell is back and the block has settled.
  task automatic wait_idle();
    seg_valid <= 1'b0;
    @(posedge clk);
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(logic [hglw_pkg::CAP_BITS-1:0] value);
    wait_idle();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    line_cap = value;
  endtask

  // Extremes of the coordinates, points, axis lines and rounding ties at reset capacity.
  task automatic test_directed_lines();
    tx_idle = 16;
    rx_idle = 85;
    send_segment(segment(0, 0, 0, 0));
    send_segment(segment(32767, 32767, 32767, 32767));
    send_segment(segment(-32768, -32768, -32768, -32768));
    send_segment(segment(0, 0, 5, 0));
    send_segment(segment(0, 0, 0, -7));
    send_segment(segment(0, 0, 3, -3));
    send_segment(segment(0, 0, 1, 1));
    send_segment(segment(0, 0, 2, -1));
    send_segment(segment(1, 2, -3, 4));
    send_segment(segment(-5, 9, 7, -2));
    send_segment(segment(0, 0, 63, 0));
    send_segment(segment(0, 0, 64, -10));
    send_segment(segment(-32768, 0, 32767, 0));
    send_segment(segment(32767, -32768, -32768, 32767));
    send_segment(segment(-32768, 32767, 32767, -32768));
    send_segment(segment(32767, 0, 32760, 7));
    send_segment(segment(-32768, 32767, -32760, 32760));
    send_segment(segment(-1, -1, 0, 0));
  endtask

  // Walk max_points through capacity one, zero, oversize, small and one above the maximum.
  task automatic test_capacity_limits();
    set_capacity(hglw_pkg::CAP_BITS'(1));
    send_segment(segment(0, 0, 10, -4));
    send_segment(segment(-32768, 32767, 32767, -32768));
    set_capacity(hglw_pkg::CAP_BITS'(0));
    send_segment(segment(3, 3, -9, 1));
    set_capacity(hglw_pkg::CAP_BITS'(127));
    send_segment(segment(0, 0, 100, -30));
    send_segment(segment(32767, 32767, -32768, -32768));
    set_capacity(hglw_pkg::CAP_BITS'(2));
    send_segment(segment(0, 0, 7, 2));
    send_segment(segment(4, -4, 4, -4));
    set_capacity(hglw_pkg::CAP_BITS'(65));
    send_segment(segment(0, 0, 70, 0));
  endtask

  // Random segments in three idling phases, with a new capacity for each.
  task automatic test_random_lines();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle = 16;
          rx_idle = 85;
          set_capacity(hglw_pkg::CAP_BITS'(hglw_pkg::MAX_POINTS));
        end
        1: begin
          tx_idle = 85;
          rx_idle = 16;
          set_capacity(hglw_pkg::CAP_BITS'($urandom_range(2, 63)));
        end
        default: begin
          tx_idle = 0;
          rx_idle = 0;
          set_capacity(hglw_pkg::CAP_BITS'($urandom_range(127)));
        end
      endcase
      repeat (PHASE_SEGMENTS) send_segment(random_segment());
    end
  endtask

  // Hold the receiver off for a long stretch while segments keep coming, so the
  // block fills up and stalls its intake.
  task automatic test_receiver_backpressure();
    set_capacity(hglw_pkg::CAP_BITS'(hglw_pkg::MAX_POINTS));
    tx_idle = 0;
    rx_idle = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (1500) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (10) send_segment(random_segment());
  endtask

  // Receiver: stall at the phase's rate, or throughout a hold-off.
  always @(posedge clk) begin
    pt_stall <= rx_hold || ($urandom_range(99) < rx_idle);
  end

  // Compare each accepted cell with the oldest owed one.
  always @(posedge clk) begin
    hglw_pkg::pt_item_t want;
    if (!rst && pt_valid && !pt_stall) begin
      if (pending_cells.size() == 0) begin
        report_mismatch($sformatf("unexpected cell q=%0d r=%0d last=%0b",
                                  pt.cell_q, pt.cell_r, pt.last_cell));
      end else begin
        want = pending_cells.pop_front();
        if (pt.cell_q !== want.cell_q)
          report_mismatch($sformatf("cell_q %0d, want %0d", pt.cell_q, want.cell_q));
        if (pt.cell_r !== want.cell_r)
          report_mismatch($sformatf("cell_r %0d, want %0d", pt.cell_r, want.cell_r));
        if (pt.last_cell !== want.last_cell)
          report_mismatch($sformatf("last_cell %0b, want %0b", pt.last_cell,
                                    want.last_cell));
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_lines();
    test_capacity_limits();
    test_random_lines();
    test_receiver_backpressure();
    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hang guard, several times the slowest correct run.
  initial begin
    #8000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/hglw_pkg.sv
design/hglw_div.sv
design/hglw_round.sv
design/hex_grid_line_walker_unit.sv
bench/hex_grid_line_walker_unit_tb.sv
